// ===== hdl/i2ctrc_pkg.sv =====
package i2ctrc_pkg;

	typedef enum logic [2:0] {
		ACT_ADDR_MATCH = 3'd0,
		ACT_STOP       = 3'd1,
		ACT_BYTE_WR    = 3'd2,
		ACT_READ_SLOT  = 3'd3,
		ACT_BUS_ERROR  = 3'd4,
		ACT_REPLY_RDY  = 3'd5,
		ACT_TICK       = 3'd6
	} action_t;

	localparam logic [1:0] CMD_NONE      = 2'd0;
	localparam logic [1:0] CMD_CONTINUE  = 2'd1;
	localparam logic [1:0] CMD_WAIT_STOP = 2'd2;

	localparam logic [7:0] EMPTY_FILL    = 8'hFF;
	localparam logic [7:0] TIMEOUT_RESET = 8'd100;
	localparam logic [7:0] ADDR_BYTES    = 8'd2;

	typedef struct packed {
		logic       ack_bit;
		logic [1:0] bus_command;
		logic [7:0] tx_byte;
		logic       push_in;
		logic       pop_out;
		logic       command_valid;
		logic [7:0] command_high;
		logic [7:0] command_low;
		logic [7:0] command_length;
		logic       fifo_reset;
		logic       busy_now;
	} result_t;

endpackage

// ===== hdl/i2c_target_register_transaction_ctrl_top.sv =====
// I2C target transaction controller.
// Event channel (evt_valid/evt_ready): one classified bus event per transfer,
// with the bus-side fields alongside. Result channel (res_valid/res_ready):
// exactly one result per event, in order.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes the busy timeout in
// ticks; always ready. The user must write it only while no event is in
// flight; the block does not enforce this. Events pass the input register,
// then the result register. Throughput: one event per cycle unless stalled;
// the state update is a single pass of logic between those two registers.
// When the result receiver stalls, the result register holds and the input
// register fills; evt_ready drops only while both are occupied, so no event
// is lost. Reset clears both registers' valid flags, all counters and flags,
// leaves the block idle, and loads the timeout register with 100 ticks.
// Bytes read while the output FIFO is empty are driven as 0xFF.
module i2c_target_register_transaction_ctrl_top
	import i2ctrc_pkg::*;
#(
	parameter int OUT_FIFO_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,

	input  logic       evt_valid,
	output logic       evt_ready,
	input  logic [2:0] action,
	input  logic [7:0] rx_byte,
	input  logic       master_nacked,
	input  logic       in_fifo_space,
	input  logic [7:0] out_byte,
	input  logic       out_valid,
	input  logic [8:0] reply_count,

	output logic       res_valid,
	input  logic       res_ready,
	output logic       ack_bit,
	output logic [1:0] bus_command,
	output logic [7:0] tx_byte,
	output logic       push_in,
	output logic       pop_out,
	output logic       command_valid,
	output logic [7:0] command_high,
	output logic [7:0] command_low,
	output logic [7:0] command_length,
	output logic       fifo_reset,
	output logic       busy_now
);

	localparam logic [8:0] DEPTH_LIM = 9'(OUT_FIFO_DEPTH);

	// configuration
	logic [7:0] timeout_ticks_q;

	// input register
	logic       valid_s1;
	logic [2:0] action_s1;
	logic [7:0] rx_byte_s1;
	logic       nacked_s1;
	logic       space_s1;
	logic [7:0] out_byte_s1;
	logic       out_valid_s1;
	logic [8:0] reply_count_s1;

	// transaction state
	logic [7:0] addr_high_q, addr_low_q, write_count_q, timeout_left_q;
	logic [8:0] send_pending_q;
	logic       first_read_q, busy_q;

	logic [7:0] addr_high_d, addr_low_d, write_count_d, timeout_left_d;
	logic [8:0] send_pending_d;
	logic       first_read_d, busy_d;

	logic       res_valid_q;
	result_t    res_q, res_d;
	logic       advance;

	logic [7:0] wc_inc;
	logic [7:0] len;
	logic [8:0] pend_dec;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			action_s1      <= action;
			rx_byte_s1     <= rx_byte;
			nacked_s1      <= master_nacked;
			space_s1       <= in_fifo_space;
			out_byte_s1    <= out_byte;
			out_valid_s1   <= out_valid;
			reply_count_s1 <= reply_count;
		end
	end

	assign wc_inc   = write_count_q + 8'd1;
	assign len      = (write_count_q > ADDR_BYTES) ? write_count_q - ADDR_BYTES : 8'd0;
	assign pend_dec = (send_pending_q != 9'd0) ? send_pending_q - 9'd1 : 9'd0;

	always_comb begin
		addr_high_d    = addr_high_q;
		addr_low_d     = addr_low_q;
		write_count_d  = write_count_q;
		timeout_left_d = timeout_left_q;
		send_pending_d = send_pending_q;
		first_read_d   = first_read_q;
		busy_d         = busy_q;
		res_d          = '0;

		case (action_t'(action_s1))
			ACT_ADDR_MATCH: begin
				res_d.bus_command = CMD_CONTINUE;
				if (!busy_q) begin
					res_d.ack_bit  = 1'b1;
					write_count_d  = '0;
					send_pending_d = '0;
				end
			end
			ACT_STOP: begin
				res_d.ack_bit     = 1'b1;
				res_d.bus_command = CMD_CONTINUE;
				if (!busy_q && (addr_high_q != 8'd0 || addr_low_q != 8'd0)) begin
					res_d.command_valid  = 1'b1;
					res_d.command_high   = addr_high_q;
					res_d.command_low    = addr_low_q;
					res_d.command_length = len;
					// no data bytes: a read follows, wait for the reply
					if (len == 8'd0) begin
						busy_d         = 1'b1;
						timeout_left_d = timeout_ticks_q;
					end
				end
				addr_high_d   = '0;
				addr_low_d    = '0;
				write_count_d = '0;
			end
			ACT_BYTE_WR: begin
				res_d.bus_command = CMD_CONTINUE;
				write_count_d     = wc_inc;
				if (wc_inc == 8'd1) begin
					addr_high_d   = rx_byte_s1;
					res_d.ack_bit = 1'b1;
				end else if (wc_inc == 8'd2) begin
					addr_low_d    = rx_byte_s1;
					res_d.ack_bit = 1'b1;
				end else if (space_s1) begin
					res_d.ack_bit = 1'b1;
					res_d.push_in = 1'b1;
				end else begin
					write_count_d = write_count_q;
				end
			end
			ACT_READ_SLOT: begin
				if (!first_read_q && nacked_s1) begin
					res_d.bus_command = CMD_WAIT_STOP;
				end else begin
					res_d.tx_byte     = out_valid_s1 ? out_byte_s1 : EMPTY_FILL;
					res_d.pop_out     = out_valid_s1;
					send_pending_d    = pend_dec;
					res_d.bus_command = (pend_dec == 9'd0) ? CMD_WAIT_STOP : CMD_CONTINUE;
					first_read_d      = 1'b0;
				end
			end
			ACT_BUS_ERROR: begin
				res_d.bus_command = CMD_WAIT_STOP;
				res_d.fifo_reset  = 1'b1;
				busy_d            = 1'b0;
				write_count_d     = '0;
				send_pending_d    = '0;
				timeout_left_d    = '0;
			end
			ACT_REPLY_RDY: begin
				if (busy_q) begin
					send_pending_d = (reply_count_s1 > DEPTH_LIM) ? DEPTH_LIM : reply_count_s1;
					first_read_d   = 1'b1;
					busy_d         = 1'b0;
					timeout_left_d = '0;
				end
			end
			ACT_TICK: begin
				if (busy_q) begin
					if (timeout_left_q <= 8'd1) begin
						timeout_left_d = '0;
						busy_d         = 1'b0;
					end else begin
						timeout_left_d = timeout_left_q - 8'd1;
					end
				end
			end
			default: begin
			end
		endcase

		res_d.busy_now = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_high_q    <= '0;
			addr_low_q     <= '0;
			write_count_q  <= '0;
			timeout_left_q <= '0;
			send_pending_q <= '0;
			first_read_q   <= 1'b0;
			busy_q         <= 1'b0;
		end else if (advance) begin
			addr_high_q    <= addr_high_d;
			addr_low_q     <= addr_low_d;
			write_count_q  <= write_count_d;
			timeout_left_q <= timeout_left_d;
			send_pending_q <= send_pending_d;
			first_read_q   <= first_read_d;
			busy_q         <= busy_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid      = res_valid_q;
	assign ack_bit        = res_q.ack_bit;
	assign bus_command    = res_q.bus_command;
	assign tx_byte        = res_q.tx_byte;
	assign push_in        = res_q.push_in;
	assign pop_out        = res_q.pop_out;
	assign command_valid  = res_q.command_valid;
	assign command_high   = res_q.command_high;
	assign command_low    = res_q.command_low;
	assign command_length = res_q.command_length;
	assign fifo_reset     = res_q.fifo_reset;
	assign busy_now       = res_q.busy_now;

endmodule

// ===== hdl/i2ctrc_checker.sv =====
module i2ctrc_checker
	import i2ctrc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       ack_bit,
	input logic [1:0] bus_command,
	input logic [7:0] tx_byte,
	input logic       push_in,
	input logic       pop_out,
	input logic       command_valid,
	input logic [7:0] command_high,
	input logic [7:0] command_low,
	input logic [7:0] command_length,
	input logic       fifo_reset,
	input logic       busy_now
);

	// stalled result must hold
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(command_high) && $stable(tx_byte)
			&& $stable(bus_command) && $stable(busy_now))
		else $error("result changed while stalled");

	// a pushed byte is always ACKed
	a_push_ack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && push_in |-> ack_bit && !pop_out && !command_valid)
		else $error("push without ACK");

	// bus error leaves the block idle, waiting for stop
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fifo_reset |-> !busy_now && bus_command == CMD_WAIT_STOP && !ack_bit)
		else $error("bus error result inconsistent");

	// a command always carries a non-zero register address
	a_cmd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && command_valid |-> (command_high != 8'd0 || command_low != 8'd0))
		else $error("command with zero address");

	// a command without data makes the block busy
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && command_valid && command_length == 8'd0 |-> busy_now)
		else $error("empty command did not set busy");

endmodule

bind i2c_target_register_transaction_ctrl_top i2ctrc_checker u_i2ctrc_checker (.*);
